>>> src/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Field widths, action and status codes, and the cell shift command.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int ACTION_WIDTH = 3;
   localparam int DATA_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_COUNT      = 3'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_DELETE     = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_LEFT,
      SHIFT_RIGHT
   } shift_mode_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      shift_mode_type mode;
      logic           load_en;
   } cell_ctrl_type;

endpackage

>>> src/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of the queue chain
// Holds one entry; shifts toward the front or back, or loads a new value.
// ----------------------------------------------------------------------------
module deq_cell
   import deq_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int IDX_W       = 4,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  cell_ctrl_type          cell_ctrl,
   input  logic [IDX_W-1:0]       load_index,
   input  logic [VALUE_WIDTH-1:0] load_data,
   input  logic [VALUE_WIDTH-1:0] left_value,
   input  logic [VALUE_WIDTH-1:0] right_value,
   output logic [VALUE_WIDTH-1:0] value
);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      case (cell_ctrl.mode)
         SHIFT_HOLD:  value_in = value_ff;
         SHIFT_LEFT:  value_in = right_value;
         SHIFT_RIGHT: value_in = left_value;
         default:     value_in = value_ff;
      endcase
      // a targeted load wins over the shift
      if (cell_ctrl.load_en && (load_index == IDX_W'(INDEX))) begin
         value_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> src/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl: request sequencer of the queue
// Decodes requests, drives the cell chain, walks it for count and delete,
// and holds the result register.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int IDX_W       = $clog2(DEPTH),
   parameter int CNT_W       = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_WIDTH-1:0] req_action,
   input  logic [DATA_WIDTH-1:0]   req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [COUNT_WIDTH-1:0]  rsp_match_count,
   output logic [COUNT_WIDTH-1:0]  rsp_length,
   output logic                    rsp_is_empty,
   output logic [DATA_WIDTH-1:0]   rsp_front_value,
   output logic [DATA_WIDTH-1:0]   rsp_back_value,
   input  logic [VALUE_WIDTH-1:0]  cell_front,
   input  logic [VALUE_WIDTH-1:0]  cell_back,
   output logic [CNT_W-1:0]        entry_count,
   output cell_ctrl_type           cell_ctrl,
   output logic [IDX_W-1:0]        load_index,
   output logic [VALUE_WIDTH-1:0]  load_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPORT
   } state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        steps_ff, steps_in;
   logic [CNT_W-1:0]        match_ff, match_in;
   logic [ACTION_WIDTH-1:0] action_ff, action_in;
   logic [VALUE_WIDTH-1:0]  val_ff, val_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]  rsp_match_ff, rsp_match_in;
   logic [COUNT_WIDTH-1:0]  rsp_length_ff, rsp_length_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [DATA_WIDTH-1:0]   rsp_front_ff, rsp_front_in;
   logic [DATA_WIDTH-1:0]   rsp_back_ff, rsp_back_in;

   logic                    accept;
   logic                    hit;
   logic                    slot_free;
   logic [VALUE_WIDTH-1:0]  req_val;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_val   = VALUE_WIDTH'(req_value);
   assign hit       = (cell_front == val_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      match_in      = match_ff;
      action_in     = action_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_length_in = rsp_length_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      cell_ctrl     = '{mode: SHIFT_HOLD, load_en: 1'b0};
      load_index    = '0;
      load_data     = req_val;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in = req_action;
               val_in    = req_val;
               status_in = STATUS_OK;
               match_in  = '0;
               steps_in  = count_ff;
               state_in  = ST_REPORT;
               case (req_action)
                  ACT_PUSH_FRONT: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cell_ctrl = '{mode: SHIFT_RIGHT, load_en: 1'b1};
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cell_ctrl  = '{mode: SHIFT_HOLD, load_en: 1'b1};
                        load_index = count_ff[IDX_W-1:0];
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cell_ctrl = '{mode: SHIFT_LEFT, load_en: 1'b0};
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ACT_COUNT, ACT_DELETE: begin
                     if (count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            // pop the front entry; push it back unless a delete drops it
            load_data  = cell_front;
            load_index = IDX_W'(count_ff - 1'b1);
            steps_in   = steps_ff - 1'b1;
            if (hit) begin
               match_in = match_ff + 1'b1;
            end
            if (hit && (action_ff == ACT_DELETE)) begin
               cell_ctrl = '{mode: SHIFT_LEFT, load_en: 1'b0};
               count_in  = count_ff - 1'b1;
            end else begin
               cell_ctrl = '{mode: SHIFT_LEFT, load_en: 1'b1};
            end
            if (steps_ff == CNT_W'(1)) begin
               state_in = ST_REPORT;
            end
         end

         ST_REPORT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_match_in  = COUNT_WIDTH'(match_ff);
               rsp_length_in = COUNT_WIDTH'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               rsp_front_in  = (count_ff == '0) ? '0 : DATA_WIDTH'(cell_front);
               rsp_back_in   = (count_ff == '0) ? '0 : DATA_WIDTH'(cell_back);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      match_ff      <= match_in;
      action_ff     <= action_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
   end

   assign entry_count     = count_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_count = rsp_match_ff;
   assign rsp_length      = rsp_length_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   a_walk_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (steps_ff != '0) && (count_ff != '0))
      else $error("walk with no entries left");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_action == ACT_PUSH_FRONT) || (req_action == ACT_PUSH_BACK))
      && (count_ff != FULL_COUNT) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the queue");

   a_report_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted without a result pending");

   a_rsp_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_length_ff == '0)))
      else $error("empty flag disagrees with length");
`endif

endmodule

>>> src/deque_with_match_count_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_match_count_delete: bounded double-ended queue
// Push and pop at either end, count or delete entries equal to a value.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (valid/ready): an action and a value. Every
//   request returns one result on rsp_* (valid/ready): status, match count,
//   length, empty flag, front and back values after the request.
//   The entries sit in a chain of DEPTH cells, front at cell 0. A push front
//   or pop front shifts the whole chain by one place.
//   Push and pop go from acceptance to the report state, which registers the
//   result once the output register is free and returns to idle for the next request.
//   Count and delete rotate the chain once per stored entry in the walk
//   state over the cells, then go on to the report state.
//   One request is in service at a time; req_ready is high while idle.
//   A finished result waits in the output register while rsp_ready is low;
//   the next request may be accepted meanwhile but cannot report until the
//   register is taken.
//   Reset (synchronous, active high) empties the queue and drops any
//   pending result. Cell contents are not cleared and are never reported.
// ----------------------------------------------------------------------------
module deque_with_match_count_delete
   import deq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_WIDTH-1:0] req_action,
   input  logic [DATA_WIDTH-1:0]   req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [COUNT_WIDTH-1:0]  rsp_match_count,
   output logic [COUNT_WIDTH-1:0]  rsp_length,
   output logic                    rsp_is_empty,
   output logic [DATA_WIDTH-1:0]   rsp_front_value,
   output logic [DATA_WIDTH-1:0]   rsp_back_value
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_back;
   logic [CNT_W-1:0]       entry_count;
   logic [IDX_W-1:0]       back_index;
   cell_ctrl_type          cell_ctrl;
   logic [IDX_W-1:0]       load_index;
   logic [VALUE_WIDTH-1:0] load_data;

   // index is garbage when empty; the sequencer masks it then
   assign back_index = IDX_W'(entry_count - 1'b1);
   assign cell_back  = cell_value[back_index];

   deq_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_count (rsp_match_count),
      .rsp_length      (rsp_length),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .cell_front      (cell_value[0]),
      .cell_back       (cell_back),
      .entry_count     (entry_count),
      .cell_ctrl       (cell_ctrl),
      .load_index      (load_index),
      .load_data       (load_data)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_value;
      logic [VALUE_WIDTH-1:0] right_value;

      // chain ends see their own value
      assign left_value  = (i == 0) ? cell_value[i] : cell_value[(i == 0) ? 0 : i - 1];
      assign right_value = (i == DEPTH - 1) ? cell_value[i]
                                            : cell_value[(i == DEPTH - 1) ? i : i + 1];

      deq_cell #(
         .INDEX       (i),
         .IDX_W       (IDX_W),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cell_ctrl   (cell_ctrl),
         .load_index  (load_index),
         .load_data   (load_data),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i])
      );
   end

endmodule
